>>> rtl/core/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg - shared types and constants of the binary min-heap queue
// Capacity, index widths, payload structs, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    // wide enough for the right child index of the deepest node
    localparam int IDX_W    = ADDR_W + 2;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [IDX_W-1:0]         idx_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam data_t EMPTY_VALUE = -32'sd1;

    typedef struct packed {
        func_t func;
        data_t value;
    } in_item_t;

    typedef struct packed {
        data_t   removed_value;
        status_t status;
        count_t  count;
        data_t   min_value;
        logic    is_empty;
    } out_item_t;

    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic    done;
        data_t   removed_value;
        status_t status;
    } sift_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAST,
        ST_UP_CHK,
        ST_UP_CMP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP
    } state_t;

endpackage

>>> rtl/core/bmh_store.sv
// ----------------------------------------------------------------------------
// bmh_store - heap element memory
// One write and one registered read per cycle; shadows entry zero as root.
// ----------------------------------------------------------------------------
module bmh_store (
    input  logic              aclk,
    input  bmh_pkg::mem_req_t req,
    output bmh_pkg::data_t    rdata,
    output bmh_pkg::data_t    root
);

    bmh_pkg::data_t mem [bmh_pkg::CAPACITY];
    bmh_pkg::data_t rdata_reg;
    bmh_pkg::data_t root_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    // keep a copy of the root so the minimum is always visible
    always_ff @(posedge aclk) begin
        if (req.we && (req.waddr == '0)) begin
            root_reg <= req.wdata;
        end
    end

    assign rdata = rdata_reg;
    assign root  = root_reg;

endmodule

>>> rtl/core/bmh_sift.sv
// ----------------------------------------------------------------------------
// bmh_sift - insert / remove sequencer
// Walks the heap one level at a time, moving a hole
// instead of swapping, and tracks the element count.
// ----------------------------------------------------------------------------
module bmh_sift (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bmh_pkg::in_item_t   item,
    input  bmh_pkg::data_t      rdata,
    input  bmh_pkg::data_t      root,
    output logic                idle,
    output bmh_pkg::count_t     count,
    output bmh_pkg::mem_req_t   req,
    output bmh_pkg::sift_res_t  res
);

    bmh_pkg::state_t  state_reg, state_next;
    bmh_pkg::addr_t   pos_reg, pos_next;
    bmh_pkg::data_t   x_reg, x_next;
    bmh_pkg::data_t   lval_reg, lval_next;
    bmh_pkg::count_t  count_reg, count_next;
    bmh_pkg::data_t   removed_reg, removed_next;
    bmh_pkg::status_t status_reg, status_next;

    bmh_pkg::idx_t    l_idx, r_idx;
    bmh_pkg::addr_t   parent;
    logic             has_l, has_r;
    logic             take_l, take_r;
    logic             full, empty;

    assign l_idx  = {1'b0, pos_reg, 1'b1};
    assign r_idx  = l_idx + bmh_pkg::IDX_W'(1);
    assign has_l  = l_idx < bmh_pkg::IDX_W'(count_reg);
    assign has_r  = r_idx < bmh_pkg::IDX_W'(count_reg);
    assign parent = (pos_reg - bmh_pkg::ADDR_W'(1)) >> 1;
    assign full   = count_reg == bmh_pkg::COUNT_W'(bmh_pkg::CAPACITY);
    assign empty  = count_reg == '0;

    // shared comparator: left wins ties, a missing right child never wins
    assign take_l = (lval_reg <= x_reg) && (!has_r || (lval_reg <= rdata));
    assign take_r = has_r && (rdata <= x_reg) && (rdata <= lval_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmh_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        x_reg       <= x_next;
        lval_reg    <= lval_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bmh_pkg::ST_IDLE: begin
                if (start) begin
                    if (item.func == bmh_pkg::FUNC_INSERT) begin
                        if (!full) begin
                            state_next = bmh_pkg::ST_UP_CHK;
                        end
                    end else if (count_reg > bmh_pkg::COUNT_W'(1)) begin
                        state_next = bmh_pkg::ST_LAST;
                    end
                end
            end
            bmh_pkg::ST_LAST:   state_next = bmh_pkg::ST_DN_L;
            bmh_pkg::ST_UP_CHK: begin
                state_next = (pos_reg == '0) ? bmh_pkg::ST_IDLE : bmh_pkg::ST_UP_CMP;
            end
            bmh_pkg::ST_UP_CMP: begin
                state_next = (rdata >= x_reg) ? bmh_pkg::ST_UP_CHK : bmh_pkg::ST_IDLE;
            end
            bmh_pkg::ST_DN_L:   state_next = has_l ? bmh_pkg::ST_DN_R : bmh_pkg::ST_IDLE;
            bmh_pkg::ST_DN_R:   state_next = bmh_pkg::ST_DN_CMP;
            bmh_pkg::ST_DN_CMP: begin
                state_next = (take_l || take_r) ? bmh_pkg::ST_DN_L : bmh_pkg::ST_IDLE;
            end
            default:            state_next = bmh_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        pos_next     = pos_reg;
        x_next       = x_reg;
        lval_next    = lval_reg;
        count_next   = count_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        req          = '0;
        res.done     = 1'b0;
        case (state_reg)
            bmh_pkg::ST_IDLE: begin
                if (start) begin
                    if (item.func == bmh_pkg::FUNC_INSERT) begin
                        removed_next = '0;
                        if (full) begin
                            status_next = bmh_pkg::STATUS_FULL;
                            res.done    = 1'b1;
                        end else begin
                            status_next = bmh_pkg::STATUS_OK;
                            pos_next    = count_reg[bmh_pkg::ADDR_W-1:0];
                            x_next      = item.value;
                            count_next  = count_reg + bmh_pkg::COUNT_W'(1);
                        end
                    end else if (empty) begin
                        removed_next = bmh_pkg::EMPTY_VALUE;
                        status_next  = bmh_pkg::STATUS_EMPTY;
                        res.done     = 1'b1;
                    end else begin
                        removed_next = root;
                        status_next  = bmh_pkg::STATUS_OK;
                        count_next   = count_reg - bmh_pkg::COUNT_W'(1);
                        pos_next     = '0;
                        // fetch the last element; it becomes the new root
                        req.re       = 1'b1;
                        req.raddr    = count_next[bmh_pkg::ADDR_W-1:0];
                        res.done     = count_reg == bmh_pkg::COUNT_W'(1);
                    end
                end
            end
            bmh_pkg::ST_LAST: begin
                x_next = rdata;
            end
            bmh_pkg::ST_UP_CHK: begin
                if (pos_reg == '0) begin
                    req.we    = 1'b1;
                    req.waddr = pos_reg;
                    req.wdata = x_reg;
                    res.done  = 1'b1;
                end else begin
                    req.re    = 1'b1;
                    req.raddr = parent;
                end
            end
            bmh_pkg::ST_UP_CMP: begin
                req.we    = 1'b1;
                req.waddr = pos_reg;
                if (rdata >= x_reg) begin
                    // pull the parent down into the hole
                    req.wdata = rdata;
                    pos_next  = parent;
                end else begin
                    req.wdata = x_reg;
                    res.done  = 1'b1;
                end
            end
            bmh_pkg::ST_DN_L: begin
                if (has_l) begin
                    req.re    = 1'b1;
                    req.raddr = l_idx[bmh_pkg::ADDR_W-1:0];
                end else begin
                    req.we    = 1'b1;
                    req.waddr = pos_reg;
                    req.wdata = x_reg;
                    res.done  = 1'b1;
                end
            end
            bmh_pkg::ST_DN_R: begin
                lval_next = rdata;
                if (has_r) begin
                    req.re    = 1'b1;
                    req.raddr = r_idx[bmh_pkg::ADDR_W-1:0];
                end
            end
            bmh_pkg::ST_DN_CMP: begin
                req.we    = 1'b1;
                req.waddr = pos_reg;
                if (take_l) begin
                    req.wdata = lval_reg;
                    pos_next  = l_idx[bmh_pkg::ADDR_W-1:0];
                end else if (take_r) begin
                    req.wdata = rdata;
                    pos_next  = r_idx[bmh_pkg::ADDR_W-1:0];
                end else begin
                    req.wdata = x_reg;
                    res.done  = 1'b1;
                end
            end
            default: begin
                req = '0;
            end
        endcase
        res.removed_value = removed_next;
        res.status        = status_next;
    end

    assign idle  = state_reg == bmh_pkg::ST_IDLE;
    assign count = count_reg;

endmodule

>>> rtl/core/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue - priority queue of signed 32-bit values
// A min-heap of up to CAPACITY entries (1024) kept in a single-port-read
// memory. Each input transfer inserts a value or removes the minimum; each
// produces exactly one result transfer with the removed value, a status, the
// new count, the current minimum and an empty flag. Removing from an empty
// heap returns -1 with the empty status; inserting into a full heap drops the
// value with the full status. One item is in work at a time and s_ready is low
// until its result has been transferred. Timing is set by the memory's single
// read port and the one shared compare step. An insert climbs level by level,
// reading the parent, comparing and pulling the parent down into the hole, and
// writes the value at the root or where it stops below; a remove fetches the
// last element, then per level descended reads the left child, reads the right
// child and compares, and then places it. Removing from an empty heap, removing
// the only element and inserting into a full heap raise m_valid at the
// accepting edge itself. s_ready returns the cycle after the result transfer,
// so a new item is not taken before the last result has gone. The memory is
// not cleared after reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bmh_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output bmh_pkg::out_item_t m_payload
);

    bmh_pkg::mem_req_t  req;
    bmh_pkg::sift_res_t res;
    bmh_pkg::data_t     rdata;
    bmh_pkg::data_t     root;
    bmh_pkg::count_t    count;
    logic               idle;
    logic               start;

    logic               m_valid_reg, m_valid_next;
    bmh_pkg::data_t     removed_reg, removed_next;
    bmh_pkg::status_t   status_reg, status_next;

    // take a new item only when the sequencer is free and no result waits
    assign s_ready = idle && !m_valid_reg;
    assign start   = s_valid && s_ready;

    bmh_sift u_sift (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .item    (s_payload),
        .rdata   (rdata),
        .root    (root),
        .idle    (idle),
        .count   (count),
        .req     (req),
        .res     (res)
    );

    bmh_store u_store (
        .aclk  (aclk),
        .req   (req),
        .rdata (rdata),
        .root  (root)
    );

    // result register: capture on completion, hold until transferred
    always_comb begin
        m_valid_next = m_valid_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res.done) begin
            m_valid_next = 1'b1;
            removed_next = res.removed_value;
            status_next  = res.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // count and root are frozen while a result waits, so read them live
    assign m_valid                 = m_valid_reg;
    assign m_payload.removed_value = removed_reg;
    assign m_payload.status        = status_reg;
    assign m_payload.count         = count;
    assign m_payload.is_empty      = count == '0;
    assign m_payload.min_value     = (count == '0) ? bmh_pkg::EMPTY_VALUE : root;

    // a result never waits while the sequencer is busy, and no input is taken
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (idle && !s_ready))
        else $error("result pending while sequencer busy or input open");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= bmh_pkg::COUNT_W'(bmh_pkg::CAPACITY))
        else $error("element count above capacity");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == bmh_pkg::STATUS_FULL))
            |-> (count == bmh_pkg::COUNT_W'(bmh_pkg::CAPACITY)))
        else $error("full status reported below capacity");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (status_reg == bmh_pkg::STATUS_EMPTY))
            |-> ((count == '0) && (removed_reg == bmh_pkg::EMPTY_VALUE)))
        else $error("empty status with stored elements");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - self-checking bench for the binary min-heap queue
// Predicts every result with a local heap model, compares each result
// transfer field by field, and covers empty removes, full-heap drops,
// duplicates and signed extremes. The bench also throttles both channels at
// random and holds off the receiver for one long stretch.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmh_pkg::*;

    // Receiver throttle patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_e;

    localparam int          SETTLE_CYCLES = 40;     // beyond the slowest remove
    localparam int unsigned HOLD_AT       = 3000;   // cycle that starts the long hold-off
    localparam int unsigned HOLD_LEN      = 500;
    localparam int          REPORT_CAP    = 40;     // mismatch lines printed at most

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the heap, queues the awaited results, checks output
    // ------------------------------------------------------------------------
    class heap_scoreboard;
        data_t       heap_mem [CAPACITY];
        int unsigned fill;
        out_item_t   awaited [$];
        int unsigned errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report_mismatch(string msg);
            if (errors < REPORT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void swap_slots(int unsigned a, int unsigned b);
            data_t t;
            t           = heap_mem[a];
            heap_mem[a] = heap_mem[b];
            heap_mem[b] = t;
        endfunction

        // climb while the parent is greater than or equal to the child
        function void raise_entry(int unsigned pos);
            int unsigned up;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (heap_mem[up] >= heap_mem[pos]) begin
                    swap_slots(up, pos);
                    pos = up;
                end else begin
                    break;
                end
            end
        endfunction

        // descend toward the smaller child; left wins ties, a missing right
        // child counts as larger than anything
        function void sink_root();
            int unsigned pos, lc, rc;
            bit          has_r;
            pos = 0;
            while (pos < fill) begin
                lc    = 2 * pos + 1;
                rc    = 2 * pos + 2;
                has_r = rc < fill;
                if (lc >= fill)
                    break;
                if (heap_mem[lc] <= heap_mem[pos] &&
                    (!has_r || heap_mem[lc] <= heap_mem[rc])) begin
                    swap_slots(pos, lc);
                    pos = lc;
                end else if (has_r && heap_mem[rc] <= heap_mem[pos] &&
                             heap_mem[rc] <= heap_mem[lc]) begin
                    swap_slots(pos, rc);
                    pos = rc;
                end else begin
                    break;
                end
            end
        endfunction

        function void note_input(in_item_t it);
            out_item_t res;
            res.removed_value = '0;
            res.status        = STATUS_OK;
            if (it.func == FUNC_INSERT) begin
                if (fill >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    heap_mem[fill] = it.value;
                    fill++;
                    raise_entry(fill - 1);
                end
            end else begin
                if (fill == 0) begin
                    res.removed_value = EMPTY_VALUE;
                    res.status        = STATUS_EMPTY;
                end else begin
                    res.removed_value = heap_mem[0];
                    heap_mem[0]       = heap_mem[fill - 1];
                    fill--;
                    sink_root();
                end
            end
            res.count     = count_t'(fill);
            res.min_value = (fill == 0) ? EMPTY_VALUE : heap_mem[0];
            res.is_empty  = (fill == 0);
            awaited = {awaited, res};
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("unexpected result %p", got));
            end else begin
                want = awaited.pop_front();
                if (got.removed_value !== want.removed_value)
                    report_mismatch($sformatf("removed_value got %0d want %0d",
                                              got.removed_value, want.removed_value));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, want.status));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              got.count, want.count));
                if (got.min_value !== want.min_value)
                    report_mismatch($sformatf("min_value got %0d want %0d",
                                              got.min_value, want.min_value));
                if (got.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty got %0b want %0b",
                                              got.is_empty, want.is_empty));
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    heap_scoreboard sb = new();

    // Sender burst bookkeeping
    int unsigned burst_left = 0;

    // Receiver throttle state, owned by the receiver process
    rx_mode_e    rx_mode      = RX_OPEN;
    int unsigned rx_mode_left = 0;
    int unsigned rx_cycle     = 0;
    int unsigned hold_left    = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    binary_min_heap_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mix signed extremes, a narrow band around zero (to force duplicates and
    // ties between children) and fully random words (to toggle every bit).
    function automatic data_t pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return -32'sd1;
                    default: return '0;
                endcase
            end
            1, 2:    return data_t'(int'($urandom_range(0, 16)) - 8);
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic func_t pick_func(int unsigned insert_pct);
        return ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
    endfunction

    // Offer one item and hold it until the transfer happens. At the start of
    // each burst, drop valid for a random gap; a gap of zero keeps valid high
    // so back-to-back items need no second assignment in the same step.
    task automatic push_op(func_t f, data_t v);
        in_item_t    it;
        int unsigned gap;
        it.func  = f;
        it.value = v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: throttle m_ready on a pattern of its own, with one long
    // hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle == HOLD_AT)
            hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            // advance to a new pattern once the current one runs out
            if (rx_mode_left == 0) begin
                rx_mode      = rx_mode_e'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(40, 300);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= $urandom_range(0, 1);
                RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_ready <= (rx_cycle % 5 != 0);
                default:     m_ready <= 1'b1;
            endcase
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_payload);
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: remove from an empty heap, signed extremes, duplicates,
        // drain back to empty (covers a missing right child on the way down),
        // then remove from empty again.
        push_op(FUNC_REMOVE, 32'sh5A5A_A5A5);
        push_op(FUNC_INSERT, 32'sh7FFF_FFFF);
        push_op(FUNC_INSERT, 32'sh8000_0000);
        push_op(FUNC_INSERT, -32'sd1);
        push_op(FUNC_INSERT, 32'sd0);
        push_op(FUNC_INSERT, 32'sh8000_0000);
        push_op(FUNC_INSERT, 32'sd5);
        push_op(FUNC_INSERT, 32'sd5);
        push_op(FUNC_INSERT, 32'sd3);
        repeat (8) push_op(FUNC_REMOVE, data_t'($urandom));
        push_op(FUNC_REMOVE, 32'sh7FFF_FFFF);
        push_op(FUNC_INSERT, 32'sd1);
        push_op(FUNC_INSERT, 32'sd2);
        push_op(FUNC_INSERT, 32'sd2);
        push_op(FUNC_REMOVE, 32'sh8000_0000);

        // Random mix around a shallow heap; empty removes still occur
        repeat (50) push_op(pick_func(55), pick_value());

        // Fill to capacity, then push past it so full-heap drops show up
        while (sb.fill < CAPACITY)
            push_op(pick_func(97), pick_value());
        repeat (12) push_op(pick_func(70), pick_value());

        // Drain with deep sift-downs through a nearly full heap
        repeat (60) push_op(pick_func(30), pick_value());

        s_valid <= 1'b0;

        // Wait out every awaited result, then let the block settle
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bmh_pkg.sv
rtl/core/bmh_store.sv
rtl/core/bmh_sift.sv
rtl/core/binary_min_heap_queue.sv
tb/tb.sv
